/* design/itrd_pkg.sv */
package itrd_pkg;

  localparam int DIGIT_W     = 8;
  localparam int POS_W       = 6;
  localparam int OUT_W       = 16;
  localparam int RADIX_W     = 9;
  localparam int COUNT_REG_W = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 2'd1;

  localparam logic [RADIX_W-1:0]     RADIX_RESET = 9'd10;
  localparam logic [COUNT_REG_W-1:0] COUNT_RESET = 7'd8;
  localparam logic [RADIX_W-1:0]     RADIX_MIN   = 9'd2;
  localparam logic [RADIX_W-1:0]     RADIX_MAX   = 9'd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } itrd_state_t;

endpackage

/* design/itrd_fifo.sv */
module itrd_fifo import itrd_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  // DEPTH is a power of two, so the pointers wrap on their own.
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      fill;

  assign full    = (fill == (AW+1)'(DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* design/itrd_front.sv */
module itrd_front import itrd_pkg::*; #(
  parameter int VALUE_WIDTH = 63,
  parameter int MAX_DIGITS  = 64,
  parameter int CW          = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [VALUE_WIDTH-1:0]            s_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data,
  input  logic                              q_full,
  output logic                              q_push,
  output logic [CW+RADIX_W+VALUE_WIDTH-1:0] q_data
);

  logic [RADIX_W-1:0]     radix;
  logic [COUNT_REG_W-1:0] digit_count;
  logic [RADIX_W-1:0]     radix_eff;
  logic [CW-1:0]          count_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= RADIX_RESET;
      digit_count <= COUNT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_RADIX) begin
        radix <= cfg_data;
      end else if (cfg_index == REG_DIGIT_COUNT) begin
        digit_count <= cfg_data[COUNT_REG_W-1:0];
      end
    end
  end

  // Clamp the registers to their legal ranges as each word is taken in.
  always_comb begin
    priority if (radix < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix;
    end
  end

  always_comb begin
    priority if (digit_count == '0) begin
      count_eff = CW'(1);
    end else if (int'(digit_count) > MAX_DIGITS) begin
      count_eff = CW'(MAX_DIGITS);
    end else begin
      count_eff = CW'(digit_count);
    end
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;
  assign q_data   = {count_eff, radix_eff, s_value};

endmodule

/* design/itrd_back.sv */
module itrd_back import itrd_pkg::*; #(
  parameter int VALUE_WIDTH = 63,
  parameter int CW          = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  output logic                              q_pop,
  input  logic [CW+RADIX_W+VALUE_WIDTH-1:0] q_data,
  output logic                              m_valid,
  input  logic                              m_ready,
  output logic [DIGIT_W-1:0]                m_digit,
  output logic [POS_W-1:0]                  m_position,
  output logic                              m_last
);

  localparam int SW = $clog2(VALUE_WIDTH);

  itrd_state_t state, state_next;

  logic [VALUE_WIDTH-1:0] quo;
  logic [RADIX_W-1:0]     rem;
  logic [RADIX_W-1:0]     rdx;
  logic [CW-1:0]          cnt;
  logic [CW-1:0]          idx;
  logic [SW-1:0]          step;
  logic [RADIX_W:0]       trial;
  logic                   fits;
  logic                   last_digit;

  // One restoring step: bring in the next quotient bit and subtract if it fits.
  assign trial      = {rem, quo[VALUE_WIDTH-1]};
  assign fits       = (trial >= {1'b0, rdx});
  assign last_digit = (idx == cnt - 1'b1);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (step == '0) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (m_ready) begin
          state_next = last_digit ? ST_IDLE : ST_DIVIDE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = (state == ST_IDLE) && !q_empty;
    m_valid    = (state == ST_EMIT);
    m_digit    = rem[DIGIT_W-1:0];
    m_position = POS_W'(idx);
    m_last     = last_digit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        quo  <= q_data[VALUE_WIDTH-1:0];
        rdx  <= q_data[VALUE_WIDTH +: RADIX_W];
        cnt  <= q_data[VALUE_WIDTH+RADIX_W +: CW];
        rem  <= '0;
        idx  <= '0;
        step <= SW'(VALUE_WIDTH - 1);
      end
      ST_DIVIDE: begin
        rem  <= fits ? RADIX_W'(trial - {1'b0, rdx}) : trial[RADIX_W-1:0];
        quo  <= {quo[VALUE_WIDTH-2:0], fits};
        step <= step - 1'b1;
      end
      ST_EMIT: begin
        if (m_ready) begin
          rem  <= '0;
          idx  <= idx + 1'b1;
          step <= SW'(VALUE_WIDTH - 1);
        end
      end
      default: begin
        rem <= '0;
      end
    endcase
  end

endmodule

/* design/integer_to_radix_digits_top.sv */
// Channel  Direction  Word per handshake              Fields, low bit up
// s_*      in         one value to convert            value
// m_*      out        one digit of the run            digit, position; last on m_tlast
// cfg_*    in         one register write              cfg_index, cfg_data
//
// Each digit is worked out in the shared bit-serial divider and then held on the
// output until taken, and the back end takes the next word from the queue only
// after the last digit of the current one has gone.
// Reset (rst, synchronous) empties the queue, idles the divider and loads the
// registers with radix 10 and digit count 8.
// A two-entry queue lets the input side keep taking words while m_tready is low.
// Configuration writes are taken every cycle and apply to words accepted later.
module integer_to_radix_digits_top import itrd_pkg::*; #(
  parameter int VALUE_WIDTH = 63,
  parameter int MAX_DIGITS  = 64,
  localparam int IN_W       = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,   // value, padding above ignored
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // digit [7:0], position [13:8], zero pad
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Wide enough to hold the clamped digit count itself.
  localparam int CW     = $clog2(MAX_DIGITS + 1);
  localparam int ENTRY_W = CW + RADIX_W + VALUE_WIDTH;
  localparam int Q_DEPTH = 2;

  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_wr_data;
  logic [ENTRY_W-1:0] q_rd_data;
  logic [DIGIT_W-1:0] digit;
  logic [POS_W-1:0]   position;

  // The front end owns the registers and stamps each word with the clamped
  // radix and digit count in force when it was accepted.
  itrd_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS),
    .CW          (CW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_value   (s_tdata[VALUE_WIDTH-1:0]),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  itrd_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  // The back end divides repeatedly by the radix; each remainder is a digit.
  itrd_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .CW          (CW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (q_rd_data),
    .m_valid    (m_tvalid),
    .m_ready    (m_tready),
    .m_digit    (digit),
    .m_position (position),
    .m_last     (m_tlast)
  );

  assign m_tdata = {(OUT_W - DIGIT_W - POS_W)'(0), position, digit};

endmodule

/* design/itrd_checker.sv */
module itrd_checker import itrd_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);

  logic [POS_W-1:0] exp_pos;
  logic [3:0]       pending;
  logic             in_acc;
  logic             run_done;

  assign in_acc   = s_tvalid && s_tready;
  assign run_done = m_tvalid && m_tready && m_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_pos <= '0;
      pending <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        exp_pos <= m_tlast ? '0 : exp_pos + 1'b1;
      end
      if (in_acc && !run_done) begin
        pending <= pending + 1'b1;
      end else if (run_done && !in_acc) begin
        pending <= pending - 1'b1;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_position: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[13:8] == exp_pos)
    else $error("digit position out of sequence");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != '0)
    else $error("digit shown with no value outstanding");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind integer_to_radix_digits_top itrd_checker u_itrd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

/* verif/integer_to_radix_digits_top_tb.sv */
// Self-checking bench for the radix digit converter. Each accepted value is expanded into
// the digits the block must return, and every digit word on the master side is checked
// against the oldest one still owed.
module integer_to_radix_digits_top_tb;
  import itrd_pkg::*;

  localparam int VALUE_WIDTH = 63;
  localparam int MAX_DIGITS  = 64;
  localparam int IN_W        = 64;

  // Digits come out all through a long word, so the longest quiet stretch is one receiver
  // stall plus one digit, far below this limit.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  // Indexes outside the register map. Writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic [IN_W-1:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [IN_W-1:0] PAD_BIT   = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   position;
    logic               last;
  } digit_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // The bench's own copy of the two registers. It follows the writes that the block
  // accepts.
  logic [RADIX_W-1:0]     radix_reg = RADIX_RESET;
  logic [COUNT_REG_W-1:0] count_reg = COUNT_RESET;

  logic [IN_W-1:0] pending_values[$];
  digit_t          digits_due[$];
  digit_t          got_digit;
  digit_t          want_digit;
  int              mismatch_count = 0;
  int              idle_cycles = 0;

  // Sender burst and gap state, and the receiver stall state. The stimulus process
  // changes gap_max and stall_mode from phase to phase, so some phases run with no
  // idling at all.
  int burst_left = 0;
  int gap_left = 0;
  int gap_max = 0;
  int stall_left = 0;
  int stall_mode = 0;

  integer_to_radix_digits_top #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // value [62:0], pad [63] ignored
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // digit [7:0], position [13:8], zero pad [15:14]
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expands one accepted value into the digits it owes, under the registers as they
  // stand now. Out-of-range radix and count settings are clamped, and the pad bit
  // above the value is dropped.
  function automatic void expand_digits(input logic [IN_W-1:0] word);
    logic [VALUE_WIDTH-1:0] rest;
    logic [RADIX_W-1:0]     base;
    logic [COUNT_REG_W-1:0] count;
    digit_t                 d;
    rest = word[VALUE_WIDTH-1:0];
    if (radix_reg < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_reg > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix_reg;
    end
    if (count_reg == '0) begin
      count = 7'd1;
    end else if (count_reg > COUNT_REG_W'(MAX_DIGITS)) begin
      count = COUNT_REG_W'(MAX_DIGITS);
    end else begin
      count = count_reg;
    end
    for (int k = 0; k < int'(count); k++) begin
      d.digit    = DIGIT_W'(rest % base);
      d.position = POS_W'(k);
      d.last     = (k == int'(count) - 1);
      digits_due = {digits_due, d};
      rest = rest / base;
    end
  endfunction

  // Appends one value to the sender's backlog.
  function automatic void queue_value(input logic [IN_W-1:0] val);
    pending_values = {pending_values, val};
  endfunction

  // Sender. It hands out words from the pending queue in bursts of random length with
  // random gaps between them. A word stays on the bus until it is taken. The digits it
  // owes are recorded at the edge where it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expand_digits(s_tdata);
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_values.size() != 0) begin
          s_tdata <= pending_values.pop_front();
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 8);
            gap_left = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker. Each digit word is compared with the oldest digit still owed.
  // The same block runs the watchdog and the receiver's stall pattern. Short stalls hit
  // single digits. Long stalls let the input queue fill up behind the output.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
      idle_cycles = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_digit = {m_tdata[DIGIT_W-1:0], m_tdata[DIGIT_W+POS_W-1:DIGIT_W], m_tlast};
        if (digits_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("digit with none owed: digit %0d position %0d last %0b",
                     got_digit.digit, got_digit.position, got_digit.last);
          end
        end else begin
          want_digit = digits_due.pop_front();
          if (got_digit !== want_digit) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("digit mismatch: expected digit %0d position %0d last %0b, got %0d %0d %0b",
                       want_digit.digit, want_digit.position, want_digit.last,
                       got_digit.digit, got_digit.position, got_digit.last);
            end
          end
        end
      end

      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("integer_to_radix_digits_top_tb NOT OK");
        $finish;
      end

      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (stall_mode != 0 && $urandom_range(0, 5) == 0) begin
        stall_left = (stall_mode == 1) ? $urandom_range(1, 4) : $urandom_range(20, 300);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Writes one register and, once the block accepts it, updates the bench's copy.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_RADIX: radix_reg = data;
      REG_DIGIT_COUNT: count_reg = data[COUNT_REG_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Every word yields at least one digit. So once nothing is queued, nothing is on the
  // bus and no digit is owed, the block is idle and the registers may change.
  task automatic wait_idle();
    while (pending_values.size() != 0 || s_tvalid || digits_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    logic [IN_W-1:0] v;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed phases. The first one uses the reset settings: radix 10, eight digits.
    // It covers zero, the largest value, and a set pad bit that must be ignored.
    stall_mode = 1;
    gap_max = 3;
    queue_value(64'd0);
    queue_value(64'd12345678);
    queue_value(VALUE_MAX);
    queue_value(PAD_BIT | 64'd987654321);
    wait_idle();

    // A radix of zero acts as two. A count of 64 gives the full run of bits.
    write_reg(REG_RADIX, 9'd0);
    write_reg(REG_DIGIT_COUNT, 9'd64);
    queue_value(VALUE_MAX);
    queue_value(64'h4000_0000_0000_0000);
    wait_idle();

    // A radix of one acts as two. A count of zero gives a single digit.
    write_reg(REG_RADIX, 9'd1);
    write_reg(REG_DIGIT_COUNT, 9'd0);
    queue_value(64'd5);
    queue_value(64'd0);
    wait_idle();

    // With the largest radix each digit is one byte. A count of 127 clamps to 64.
    stall_mode = 0;
    gap_max = 0;
    write_reg(REG_RADIX, 9'd256);
    write_reg(REG_DIGIT_COUNT, 9'd127);
    queue_value(VALUE_MAX);
    queue_value(64'h0123_4567_89AB_CDEF);
    wait_idle();

    // A radix above the limit clamps to 256. A count just above the limit clamps to 64.
    write_reg(REG_RADIX, 9'd511);
    write_reg(REG_DIGIT_COUNT, 9'd65);
    queue_value(PAD_BIT | 64'h7EDC_BA98_7654_3210);
    wait_idle();
    write_reg(REG_RADIX, 9'd257);
    write_reg(REG_DIGIT_COUNT, 9'd8);
    queue_value(VALUE_MAX);
    wait_idle();

    // Radix three with forty digits uses every digit of the largest value.
    stall_mode = 2;
    gap_max = 10;
    write_reg(REG_RADIX, 9'd3);
    write_reg(REG_DIGIT_COUNT, 9'd40);
    queue_value(VALUE_MAX);
    wait_idle();

    // Writes to the unused indexes must leave radix 7 and three digits in force.
    write_reg(REG_RADIX, 9'd7);
    write_reg(REG_DIGIT_COUNT, 9'd3);
    write_reg(REG_SPARE_A, 9'h1FF);
    write_reg(REG_SPARE_B, 9'd0);
    queue_value(64'd1000);
    queue_value(64'd48);
    queue_value(64'd342);
    wait_idle();

    // Random phases. Each picks its own settings, sender gaps and receiver stalls.
    // Counts stay mostly small so that the run stays short. Now and then a phase takes
    // the full 64 digits or an out-of-range setting. Values are shifted down by a random
    // amount so that short values come up as often as long ones.
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 9))
        0: write_reg(REG_RADIX, 9'($urandom_range(0, 511)));
        1: write_reg(REG_RADIX, RADIX_MIN);
        2: write_reg(REG_RADIX, RADIX_MAX);
        default: write_reg(REG_RADIX, 9'($urandom_range(2, 256)));
      endcase
      case ($urandom_range(0, 9))
        0: write_reg(REG_DIGIT_COUNT, 9'($urandom_range(0, 127)));
        1: write_reg(REG_DIGIT_COUNT, 9'd64);
        default: write_reg(REG_DIGIT_COUNT, 9'($urandom_range(1, 12)));
      endcase
      stall_mode = $urandom_range(0, 2);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      for (int n = 0; n < 10; n++) begin
        v = {$urandom, $urandom};
        v[VALUE_WIDTH-1:0] = v[VALUE_WIDTH-1:0] >> $urandom_range(0, VALUE_WIDTH - 1);
        v[IN_W-1] = ($urandom_range(0, 7) == 0);
        queue_value(v);
      end
      wait_idle();
    end

    // Let any stray digits show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && digits_due.size() == 0) begin
      $display("integer_to_radix_digits_top_tb OK");
    end else begin
      $display("integer_to_radix_digits_top_tb NOT OK");
    end
    $finish;
  end

endmodule
